FILE: rtl/u16d_pkg.sv
// ----------------------------------------------------------------------------
// u16d_pkg
// Shared types and constants of the UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u16d_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned OFF_W           = 32;
  localparam int unsigned CP_W            = 21;
  localparam int unsigned QUEUE_DEPTH     = 4;

  // Byte order mode register codes.
  localparam logic [1:0] MODE_LE     = 2'd0;
  localparam logic [1:0] MODE_BE     = 2'd1;
  localparam logic [1:0] MODE_DETECT = 2'd2;

  localparam logic [7:0] BOM_FE = 8'hFE;
  localparam logic [7:0] BOM_FF = 8'hFF;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_END  = 2'd1,
    ST_ODD  = 2'd2,
    ST_SURR = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [1:0]       status;
    logic [OFF_W-1:0] unit_offset;
    logic             big_endian_active;
    logic             run_last;
  } out_word_t;

  // Words handed from the decode stage to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } push_t;

endpackage

FILE: rtl/u16d_out_queue.sv
// ----------------------------------------------------------------------------
// u16d_out_queue
// Small queue: takes up to two words per cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module u16d_out_queue
  import u16d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  out_word_t        mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             pop;
  logic [PtrW-1:0]  wr_next;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  // Room for the largest burst the decoder can produce.
  assign room_o      = (cnt_q <= CntW'(QUEUE_DEPTH - 2));
  assign wr_next     = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.count);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push without room");

  a_pop_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("queue count did not drop on a pop");

endmodule

FILE: rtl/u16d_decode.sv
// ----------------------------------------------------------------------------
// u16d_decode
// Input register and single-pass decode of one byte into up to two words.
// ----------------------------------------------------------------------------
module u16d_decode
  import u16d_pkg::*;
#(
  parameter int unsigned OffsetBits = OFFSET_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  input  logic       room_i,
  output push_t      push_o
);

  localparam int unsigned WideW = (OffsetBits > OFF_W) ? OffsetBits : OFF_W;

  function automatic logic [OFF_W-1:0] sat_off(input logic [OffsetBits-1:0] v);
    logic [WideW-1:0] w;
    w = WideW'(v);
    if (w > WideW'({OFF_W{1'b1}})) begin
      return '1;
    end
    return w[OFF_W-1:0];
  endfunction

  logic                  vld_q, vld_d;
  in_word_t              in_q;
  logic                  adv;
  logic [OffsetBits-1:0] pos_q, pos_d, pos_inc;
  logic [OffsetBits-1:0] seq_q, seq_d;
  logic [7:0]            held_q, held_d;
  logic                  phase_q, phase_d;
  logic [15:0]           hs_q, hs_d;
  logic                  hold_hi_q, hold_hi_d;
  logic                  big_q, big_d;
  logic                  mark_q, mark_d;
  logic                  disc_q, disc_d;

  logic                  ab;
  logic [15:0]           unit;
  logic                  skip, err, restart;
  logic [7:0]            b;
  logic                  fin;

  assign adv        = vld_q && room_i;
  assign in_stall_o = vld_q && !room_i;
  assign vld_d      = (in_valid_i && !in_stall_o) ? 1'b1 : (adv ? 1'b0 : vld_q);
  assign b          = in_q.in_byte;
  assign fin        = in_q.final_byte;
  assign pos_inc    = (&pos_q) ? pos_q : pos_q + OffsetBits'(1);

  always_comb begin
    ab        = mark_q ? (mode_i == MODE_BE) : big_q;
    unit      = ab ? {held_q, b} : {b, held_q};
    skip      = 1'b0;
    err       = 1'b0;
    restart   = 1'b0;
    pos_d     = pos_q;
    seq_d     = seq_q;
    held_d    = held_q;
    phase_d   = phase_q;
    hs_d      = hs_q;
    hold_hi_d = hold_hi_q;
    big_d     = big_q;
    mark_d    = mark_q;
    disc_d    = disc_q;
    push_o    = '0;

    if (adv) begin
      pos_d = pos_inc;
      if (disc_q) begin
        if (fin) begin
          push_o.count = 2'd1;
          push_o.first = '{code_point: '0, status: ST_END, unit_offset: sat_off(pos_inc),
                           big_endian_active: ab, run_last: 1'b1};
          restart = 1'b1;
        end
        big_d = ab;
      end else if (!phase_q) begin
        held_d  = b;
        phase_d = 1'b1;
        big_d   = ab;
        if (!hold_hi_q) begin
          seq_d = pos_q;
        end
        if (fin) begin
          push_o.count = 2'd1;
          push_o.first = '{code_point: '0,
                           status: hold_hi_q ? ST_SURR : ST_ODD,
                           unit_offset: sat_off(hold_hi_q ? seq_q : pos_q),
                           big_endian_active: ab, run_last: 1'b1};
          restart = 1'b1;
        end
      end else begin
        phase_d = 1'b0;
        if (mark_q) begin
          mark_d = 1'b0;
          if (mode_i == MODE_DETECT) begin
            if (held_q == BOM_FE && b == BOM_FF) begin
              ab   = 1'b1;
              skip = 1'b1;
            end else if (held_q == BOM_FF && b == BOM_FE) begin
              ab   = 1'b0;
              skip = 1'b1;
            end
          end
        end
        big_d = ab;

        if (!skip) begin
          if (hold_hi_q) begin
            if (unit[15:10] == LO_SURR_TAG) begin
              hold_hi_d    = 1'b0;
              push_o.count = 2'd1;
              push_o.first = '{code_point: SUPP_BASE + CP_W'({hs_q[9:0], unit[9:0]}),
                               status: ST_OK, unit_offset: sat_off(seq_q),
                               big_endian_active: ab, run_last: 1'b0};
            end else begin
              err = 1'b1;
            end
          end else if (unit[15:10] == HI_SURR_TAG) begin
            hs_d      = unit;
            hold_hi_d = 1'b1;
            err       = fin;
          end else if (unit[15:10] == LO_SURR_TAG) begin
            err = 1'b1;
          end else begin
            push_o.count = 2'd1;
            push_o.first = '{code_point: CP_W'(unit), status: ST_OK,
                             unit_offset: sat_off(seq_q),
                             big_endian_active: ab, run_last: 1'b0};
          end
        end

        if (err) begin
          push_o.count = 2'd1;
          push_o.first = '{code_point: '0, status: ST_SURR, unit_offset: sat_off(seq_q),
                           big_endian_active: ab, run_last: fin};
          if (fin) begin
            restart = 1'b1;
          end else begin
            disc_d = 1'b1;
          end
        end else if (fin) begin
          // The end word follows any code point that this byte completed.
          if (push_o.count == 2'd1) begin
            push_o.count  = 2'd2;
            push_o.second = '{code_point: '0, status: ST_END,
                              unit_offset: sat_off(pos_inc),
                              big_endian_active: ab, run_last: 1'b1};
          end else begin
            push_o.count = 2'd1;
            push_o.first = '{code_point: '0, status: ST_END,
                             unit_offset: sat_off(pos_inc),
                             big_endian_active: ab, run_last: 1'b1};
          end
          restart = 1'b1;
        end
      end

      if (restart) begin
        pos_d     = '0;
        seq_d     = '0;
        held_d    = '0;
        phase_d   = 1'b0;
        hs_d      = '0;
        hold_hi_d = 1'b0;
        big_d     = (mode_i == MODE_BE);
        mark_d    = 1'b1;
        disc_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      pos_q     <= '0;
      seq_q     <= '0;
      held_q    <= '0;
      phase_q   <= 1'b0;
      hs_q      <= '0;
      hold_hi_q <= 1'b0;
      big_q     <= 1'b0;
      mark_q    <= 1'b1;
      disc_q    <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      pos_q     <= pos_d;
      seq_q     <= seq_d;
      held_q    <= held_d;
      phase_q   <= phase_d;
      hs_q      <= hs_d;
      hold_hi_q <= hold_hi_d;
      big_q     <= big_d;
      mark_q    <= mark_d;
      disc_q    <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  a_pair_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (push_o.first.status == ST_OK &&
      push_o.second.status == ST_END && push_o.second.run_last))
    else $error("two words per byte must be a code point and an end word");

  a_last_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd1 && push_o.first.run_last) |=>
      (mark_q && !phase_q && !disc_q && !hold_hi_q && pos_q == '0))
    else $error("stream state not cleared after the closing word");

  a_error_discards : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd1 && push_o.first.status == ST_SURR && !push_o.first.run_last)
      |=> disc_q)
    else $error("mid-stream error did not enter discard");

endmodule

FILE: rtl/utf16_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf16_stream_decoder_top
// UTF-16 byte stream decoder with byte order mark detection.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle while the input is not stalled:
// the byte is registered, decoded in one pass against the stream state, and
// the resulting words go into a four-word output queue. A byte yields zero,
// one or two words, and only a final byte that completes a unit yields two;
// the byte before it yields none, so with an output that never stalls the
// queue holds at most two words and the input never stalls. The input stalls
// only when the consumer stalls the output until the queue holds more than
// two words. Write the mode register only while the decoder is idle; the byte
// order it selects holds until the first unit of a stream completes, then
// stays fixed until the final byte.
module utf16_stream_decoder_top
  import u16d_pkg::*;
#(
  parameter int unsigned OffsetBits = OFFSET_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_data_o
);

  logic [1:0] mode_q;
  push_t      push;
  logic       room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LE;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  u16d_decode #(
    .OffsetBits(OffsetBits)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mode_i    (mode_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .room_i    (room),
    .push_o    (push)
  );

  u16d_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: dv/tb_utf16_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_utf16_stream_decoder_top
// Self-checking bench for the UTF-16 stream decoder. A directed table walks
// the byte order modes, the mark, surrogate pairs and every error status;
// then random streams, mostly well formed with some noise, run through all
// modes under random input gaps and output stalls. Each output word is checked
// field by field against a checked row's typed word, else a cycle-free model.
// ----------------------------------------------------------------------------
module tb_utf16_stream_decoder_top;
  import u16d_pkg::*;

  localparam int unsigned OFF_BITS    = OFFSET_BITS_DEF;
  localparam int          DRAIN_CYC   = 8;
  localparam int          RAND_BYTES  = 450;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam longint unsigned POS_MAX = (OFF_BITS >= 64) ? '1 : ((64'd1 << OFF_BITS) - 1);

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;

  utf16_stream_decoder_top #(
    .OffsetBits(OFF_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Decoder model state.
  logic [1:0]      mode_q;
  longint unsigned byte_cnt;
  longint unsigned seq_off;
  logic [7:0]      first_byte;
  logic            half_unit;
  logic [15:0]     hi_unit;
  logic            have_hi;
  logic            order_big;
  logic            mark_open;
  logic            dropping;

  out_word_t pending_words[$];  // words the decoder still owes
  out_word_t step_words[$];     // words caused by the byte just accepted
  logic [7:0] stream_bytes[$];

  int  n_bad;
  int  n_sent;
  bit  calm;
  int  cyc;
  int  stall_left;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc % 200 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  function automatic void report(string msg);
    n_bad++;
    if (n_bad <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void restart_stream();
    byte_cnt   = 0;
    seq_off    = 0;
    first_byte = '0;
    half_unit  = 1'b0;
    hi_unit    = '0;
    have_hi    = 1'b0;
    order_big  = (mode_q == MODE_BE);
    mark_open  = 1'b1;
    dropping   = 1'b0;
  endfunction

  function automatic void emit(logic [CP_W-1:0] cp, status_e st, longint unsigned off,
                               logic last);
    out_word_t w;
    w.code_point        = cp;
    w.status            = st;
    w.unit_offset       = (off > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : off[31:0];
    w.big_endian_active = order_big;
    w.run_last          = last;
    step_words.push_back(w);
  endfunction

  // Applies one byte to the model and leaves the words it causes in step_words.
  function automatic void decode_byte(logic [7:0] b, logic fin);
    longint unsigned here;
    logic [15:0] unit;
    logic skip;
    logic err;
    here = byte_cnt;
    skip = 1'b0;
    err  = 1'b0;
    if (mark_open) order_big = (mode_q == MODE_BE);
    if (byte_cnt < POS_MAX) byte_cnt++;
    if (dropping) begin
      if (fin) begin
        emit('0, ST_END, byte_cnt, 1'b1);
        restart_stream();
      end
      return;
    end
    if (!half_unit) begin
      first_byte = b;
      half_unit  = 1'b1;
      if (!have_hi) seq_off = here;
      if (fin) begin
        emit('0, have_hi ? ST_SURR : ST_ODD, seq_off, 1'b1);
        restart_stream();
      end
      return;
    end
    half_unit = 1'b0;
    unit = order_big ? {first_byte, b} : {b, first_byte};
    if (mark_open) begin
      mark_open = 1'b0;
      if (mode_q == MODE_DETECT) begin
        if (first_byte == BOM_FE && b == BOM_FF) begin
          order_big = 1'b1;
          skip = 1'b1;
        end else if (first_byte == BOM_FF && b == BOM_FE) begin
          order_big = 1'b0;
          skip = 1'b1;
        end
      end
    end
    if (!skip) begin
      if (have_hi) begin
        if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
          have_hi = 1'b0;
          emit(SUPP_BASE + {1'b0, hi_unit[9:0], unit[9:0]}, ST_OK, seq_off, 1'b0);
        end else begin
          err = 1'b1;
        end
      end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
        hi_unit = unit;
        have_hi = 1'b1;
        if (fin) err = 1'b1;
      end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
        err = 1'b1;
      end else begin
        emit({5'd0, unit}, ST_OK, seq_off, 1'b0);
      end
    end
    if (err) begin
      emit('0, ST_SURR, seq_off, fin);
      if (fin) restart_stream();
      else dropping = 1'b1;
      return;
    end
    if (fin) begin
      emit('0, ST_END, byte_cnt, 1'b1);
      restart_stream();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Output side stalls: mostly short bursts, a few long; none start while calm.
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm || r < 60) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word cp=%h st=%0d off=%0d be=%b last=%b",
                         out_data_o.code_point, out_data_o.status, out_data_o.unit_offset,
                         out_data_o.big_endian_active, out_data_o.run_last));
      end else begin
        want = pending_words.pop_front();
        if (out_data_o.code_point !== want.code_point ||
            out_data_o.status !== want.status ||
            out_data_o.unit_offset !== want.unit_offset ||
            out_data_o.big_endian_active !== want.big_endian_active ||
            out_data_o.run_last !== want.run_last)
          report({$sformatf("mismatch exp cp=%h st=%0d off=%0d be=%b last=%b,",
                            want.code_point, want.status, want.unit_offset,
                            want.big_endian_active, want.run_last),
                  $sformatf(" got cp=%h st=%0d off=%0d be=%b last=%b",
                            out_data_o.code_point, out_data_o.status,
                            out_data_o.unit_offset, out_data_o.big_endian_active,
                            out_data_o.run_last)});
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin, bit chk, out_word_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, final_byte: fin};
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
    decode_byte(b, fin);
    if (chk) pending_words.push_back(want);
    else foreach (step_words[i]) pending_words.push_back(step_words[i]);
    step_words.delete();
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  // Bytes that cause no word may still be in flight, so wait a little longer.
  task automatic write_mode(logic [1:0] m);
    hold_until_drained();
    repeat (DRAIN_CYC) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    mode_q = m;
    if (mark_open) order_big = (m == MODE_BE);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_unit(logic [15:0] u, bit big);
    if (big) begin
      stream_bytes.push_back(u[15:8]);
      stream_bytes.push_back(u[7:0]);
    end else begin
      stream_bytes.push_back(u[7:0]);
      stream_bytes.push_back(u[15:8]);
    end
  endfunction

  function automatic logic [15:0] plain_unit();
    logic [15:0] u;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'hD7FF;
        default: return 16'hE000;
      endcase
    end
    do u = 16'($urandom_range(0, 16'hFFFF)); while (u >= 16'hD800 && u <= 16'hDFFF);
    return u;
  endfunction

  // Builds one random stream in stream_bytes, mostly well formed.
  function automatic void make_stream();
    bit big;
    int units;
    int r;
    logic [19:0] sv;
    stream_bytes.delete();
    big = (mode_q == MODE_BE);
    if (mode_q == MODE_DETECT && $urandom_range(0, 1)) begin
      big = 1'($urandom_range(0, 1));
      add_unit(16'hFEFF, big);
    end
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    units = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
    repeat (units) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        add_unit(plain_unit(), big);
      end else if (r < 87) begin
        sv = 20'($urandom_range(0, 20'hFFFFF));
        add_unit(16'hD800 | sv[19:10], big);
        add_unit(16'hDC00 | sv[9:0], big);
      end else if (r < 92) begin
        add_unit(16'hDC00 | 10'($urandom_range(0, 1023)), big);
      end else if (r < 96) begin
        add_unit(16'hD800 | 10'($urandom_range(0, 1023)), big);
        add_unit(plain_unit(), big);
      end else begin
        add_unit(16'($urandom_range(0, 16'hFFFF)), big);
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      stream_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (r < 13) begin
      add_unit(16'hD800 | 10'($urandom_range(0, 1023)), big);
      if ($urandom_range(0, 1)) stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (stream_bytes.size() == 0) add_unit(plain_unit(), big);
  endfunction

  typedef struct packed {
    logic       is_cfg;
    logic [7:0] val;     // byte, or mode on a register row
    logic       fin;
    logic       chk;     // expected word typed in below
    status_e    st;
    logic [7:0] off;
    logic       be;
    logic       last;
  } row_t;

  row_t dir_rows [30] = '{
    '{1'b1, 8'(MODE_LE),     1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    // odd single byte
    '{1'b0, 8'hAB, 1'b1, 1'b1, ST_ODD,  8'd0, 1'b0, 1'b1},
    // U+0000 then U+10FFFF
    '{1'b0, 8'h00, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h00, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hDB, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hDF, 1'b1, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    // lone low surrogate, then the rest of the stream is dropped
    '{1'b0, 8'h00, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hDC, 1'b0, 1'b1, ST_SURR, 8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h12, 1'b1, 1'b1, ST_END,  8'd3, 1'b0, 1'b1},
    // high surrogate cut short by an odd final byte
    '{1'b0, 8'h00, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hD8, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h41, 1'b1, 1'b1, ST_SURR, 8'd0, 1'b0, 1'b1},
    '{1'b1, 8'(MODE_BE),     1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hD8, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h3D, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hDE, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h00, 1'b1, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b1, 8'(MODE_DETECT), 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    // a stream that holds only a big endian mark
    '{1'b0, 8'hFE, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hFF, 1'b1, 1'b1, ST_END,  8'd2, 1'b1, 1'b1},
    '{1'b0, 8'hFF, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hFE, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h41, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'h00, 1'b1, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    // the unused mode decodes little endian and does not look for a mark
    '{1'b1, 8'(MODE_UNUSED), 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hFF, 1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b0, 8'hFE, 1'b1, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0},
    '{1'b1, 8'(MODE_LE),     1'b0, 1'b0, ST_OK,   8'd0, 1'b0, 1'b0}
  };

  initial begin
    out_word_t want;
    logic [1:0] phase_modes[4];
    int phase;
    bit pressed;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = MODE_LE;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    n_bad       = 0;
    n_sent      = 0;
    calm        = 1'b0;
    cyc         = 0;
    stall_left  = 0;
    pressed     = 1'b0;
    mode_q      = MODE_LE;
    restart_stream();
    phase_modes = '{MODE_DETECT, MODE_BE, MODE_UNUSED, MODE_LE};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_mode(dir_rows[i].val[1:0]);
      end else begin
        want.code_point        = '0;
        want.status            = dir_rows[i].st;
        want.unit_offset       = {24'd0, dir_rows[i].off};
        want.big_endian_active = dir_rows[i].be;
        want.run_last          = dir_rows[i].last;
        send_byte(dir_rows[i].val, dir_rows[i].fin, dir_rows[i].chk, want);
      end
    end

    phase  = 0;
    while (n_sent < RAND_BYTES) begin
      write_mode(phase < 4 ? phase_modes[phase] : 2'($urandom_range(0, 3)));
      phase++;
      repeat ($urandom_range(3, 8)) begin
        if (n_sent >= RAND_BYTES) break;
        make_stream();
        foreach (stream_bytes[i]) begin
          // Once, the sender waits in mid stream until the decoder has caught up.
          if (!pressed && stream_bytes.size() >= 4 && i == stream_bytes.size() / 2) begin
            hold_until_drained();
            pressed = 1'b1;
          end
          send_byte(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
        end
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (pending_words.size() != 0)
      report($sformatf("%0d expected words never came", pending_words.size()));
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/u16d_pkg.sv
rtl/u16d_out_queue.sv
rtl/u16d_decode.sv
rtl/utf16_stream_decoder_top.sv
dv/tb_utf16_stream_decoder_top.sv
